// ----- hdl/grapheme_break_step_assert.svh -----
// grapheme_break_step_assert.svh
// Assertion macros shared by the grapheme break step RTL.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef GRAPHEME_BREAK_STEP_ASSERT_SVH
`define GRAPHEME_BREAK_STEP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grapheme_break_step: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grapheme_break_step: next-cycle check failed");

`endif

// ----- hdl/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// Class codes, Indic conjunct codes and the item, result and state records
// shared by the grapheme break step modules.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int ClsW  = 5;
	localparam int IncbW = 2;

	// Grapheme break classes
	localparam logic [ClsW-1:0] BC_START       = 5'd0;
	localparam logic [ClsW-1:0] BC_OTHER       = 5'd1;
	localparam logic [ClsW-1:0] BC_CR          = 5'd2;
	localparam logic [ClsW-1:0] BC_LF          = 5'd3;
	localparam logic [ClsW-1:0] BC_CONTROL     = 5'd4;
	localparam logic [ClsW-1:0] BC_EXTEND      = 5'd5;
	localparam logic [ClsW-1:0] BC_L           = 5'd6;
	localparam logic [ClsW-1:0] BC_V           = 5'd7;
	localparam logic [ClsW-1:0] BC_T           = 5'd8;
	localparam logic [ClsW-1:0] BC_LV          = 5'd9;
	localparam logic [ClsW-1:0] BC_LVT         = 5'd10;
	localparam logic [ClsW-1:0] BC_RI          = 5'd11;
	localparam logic [ClsW-1:0] BC_SPACINGMARK = 5'd12;
	localparam logic [ClsW-1:0] BC_PREPEND     = 5'd13;
	localparam logic [ClsW-1:0] BC_ZWJ         = 5'd14;
	localparam logic [ClsW-1:0] BC_EXTPICT     = 5'd15;
	localparam logic [ClsW-1:0] BC_EZWG        = 5'd16;

	// Indic conjunct classes
	localparam logic [IncbW-1:0] ICB_NONE      = 2'd0;
	localparam logic [IncbW-1:0] ICB_CONSONANT = 2'd1;
	localparam logic [IncbW-1:0] ICB_EXTEND    = 2'd2;
	localparam logic [IncbW-1:0] ICB_LINKER    = 2'd3;

	typedef struct packed {
		logic             stateful_mode;
		logic             restart;
		logic [ClsW-1:0]  left_class;
		logic [IncbW-1:0] left_incb;
		logic [ClsW-1:0]  right_class;
		logic [IncbW-1:0] right_incb;
	} gbs_item_t;

	typedef struct packed {
		logic             break_allowed;
		logic [ClsW-1:0]  next_class;
		logic [IncbW-1:0] next_incb;
	} gbs_result_t;

	typedef struct packed {
		logic             valid;
		logic [ClsW-1:0]  cls;
		logic [IncbW-1:0] incb;
	} gbs_state_t;

endpackage

// ----- hdl/grapheme_break_step.sv -----
// ----------------------------------------------------------------------------
// grapheme_break_step
// One step of extended grapheme cluster boundary detection on a pair of
// code point classes, with optional kept state across steps.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one code point pair per item
//   with its mode bits; output channel (out_valid / out_stall) returns one
//   result item per input item, in order.
//   The input register takes the item, then the decision logic loads the
//   result register once it is free or being taken. The kept class and
//   conjunct state update in the same edge that loads the result register,
//   so the next item sees it without a gap. Throughput is one item per
//   cycle while out_stall is low, set by the single decision stage.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, after which in_stall rises.
//   Reset empties both registers and clears the kept state to empty, so the
//   first stateful item seeds from its left side.
// ----------------------------------------------------------------------------
module grapheme_break_step (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     stateful_mode,
	input  logic                     restart,
	input  logic [gbs_pkg::ClsW-1:0]  left_class,
	input  logic [gbs_pkg::IncbW-1:0] left_incb,
	input  logic [gbs_pkg::ClsW-1:0]  right_class,
	input  logic [gbs_pkg::IncbW-1:0] right_incb,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     break_allowed,
	output logic [gbs_pkg::ClsW-1:0]  next_class,
	output logic [gbs_pkg::IncbW-1:0] next_incb
);
	import gbs_pkg::*;

	`include "grapheme_break_step_assert.svh"

	logic        s1_valid_q;
	gbs_item_t   item_s1;
	logic        s2_valid_q;
	gbs_result_t result_s2;
	gbs_state_t  state_q;
	gbs_result_t result_d;
	gbs_state_t  state_d;
	logic        adv;
	logic        take_in;

	// Move an item forward when the result register is free or being taken
	assign adv      = s1_valid_q && (!s2_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !adv;
	assign take_in  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{stateful_mode: stateful_mode, restart: restart,
				left_class: left_class, left_incb: left_incb,
				right_class: right_class, right_incb: right_incb};
		end
	end

	// Decision logic
	gbs_core u_core (
		.item      (item_s1),
		.state_cur (state_q),
		.result    (result_d),
		.state_nxt (state_d)
	);

	// Kept state: advance only on stateful items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv && item_s1.stateful_mode) begin
			state_q <= state_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= 1'b1;
		end else if (!out_stall) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid     = s2_valid_q;
	assign break_allowed = result_s2.break_allowed;
	assign next_class    = result_s2.next_class;
	assign next_incb     = result_s2.next_incb;

	// Checks
	`GBS_ASSERT_NOW(a_stall_has_item, in_stall, s1_valid_q)
	`GBS_ASSERT_NOW(a_no_overwrite, s2_valid_q && out_stall, !adv)
	`GBS_ASSERT_NEXT(a_state_filled, adv && item_s1.stateful_mode, state_q.valid)
	`GBS_ASSERT_NEXT(a_stateless_keeps, adv && !item_s1.stateful_mode, $stable(state_q))

endmodule

// ----- hdl/gbs_core.sv -----
// ----------------------------------------------------------------------------
// gbs_core
// Combinational boundary decision for one code point pair, with seeding and
// advance of the kept class and Indic conjunct state.
// ----------------------------------------------------------------------------
module gbs_core (
	input  gbs_pkg::gbs_item_t   item,
	input  gbs_pkg::gbs_state_t  state_cur,
	output gbs_pkg::gbs_result_t result,
	output gbs_pkg::gbs_state_t  state_nxt
);
	import gbs_pkg::*;

	// Pairwise rules GB1 through GB13
	function automatic logic pair_break(input logic [ClsW-1:0] a, input logic [ClsW-1:0] b);
		logic brk;
		begin
			brk = 1'b1;
			if (a == BC_START) begin
				brk = 1'b1;
			end else if (a == BC_CR && b == BC_LF) begin
				brk = 1'b0;
			end else if (a == BC_CR || a == BC_LF || a == BC_CONTROL) begin
				brk = 1'b1;
			end else if (b == BC_CR || b == BC_LF || b == BC_CONTROL) begin
				brk = 1'b1;
			end else if (a == BC_L && (b == BC_L || b == BC_V || b == BC_LV || b == BC_LVT)) begin
				brk = 1'b0;
			end else if ((a == BC_LV || a == BC_V) && (b == BC_V || b == BC_T)) begin
				brk = 1'b0;
			end else if ((a == BC_LVT || a == BC_T) && b == BC_T) begin
				brk = 1'b0;
			end else if (b == BC_EXTEND || b == BC_ZWJ || b == BC_SPACINGMARK ||
					a == BC_PREPEND) begin
				brk = 1'b0;
			end else if (a == BC_EZWG && b == BC_EXTPICT) begin
				brk = 1'b0;
			end else if (a == BC_RI && b == BC_RI) begin
				brk = 1'b0;
			end
			return brk;
		end
	endfunction

	// Conjunct state: consonant (extend|linker)* linker ... consonant
	function automatic logic [IncbW-1:0] incb_advance(input logic [IncbW-1:0] s,
			input logic [IncbW-1:0] t);
		logic [IncbW-1:0] r;
		begin
			if (t == ICB_CONSONANT || s == ICB_CONSONANT || s == ICB_EXTEND) begin
				r = t;
			end else if (s == ICB_LINKER) begin
				r = (t == ICB_EXTEND) ? ICB_LINKER : t;
			end else begin
				r = s;
			end
			return r;
		end
	endfunction

	// Track pictographic Extend* ZWJ runs; close a regional indicator pair
	function automatic logic [ClsW-1:0] class_advance(input logic [ClsW-1:0] s,
			input logic [ClsW-1:0] t);
		logic [ClsW-1:0] r;
		begin
			r = t;
			if (s == BC_RI && t == BC_RI) begin
				r = BC_OTHER;
			end else if (s == BC_EXTPICT && t == BC_EXTEND) begin
				r = BC_EXTPICT;
			end else if (s == BC_EXTPICT && t == BC_ZWJ) begin
				r = BC_EZWG;
			end
			return r;
		end
	endfunction

	logic             seed;
	logic [ClsW-1:0]  eff_cls;
	logic [IncbW-1:0] eff_incb;
	logic             brk_pair;

	// Pick the effective left side: seed from the item or use the kept state
	always_comb begin
		seed = !state_cur.valid || item.restart;
		if (!item.stateful_mode) begin
			eff_cls  = item.left_class;
			eff_incb = item.left_incb;
		end else if (seed) begin
			eff_cls  = item.left_class;
			eff_incb = (item.left_incb == ICB_CONSONANT) ? ICB_CONSONANT : ICB_NONE;
		end else begin
			eff_cls  = state_cur.cls;
			eff_incb = state_cur.incb;
		end
		brk_pair = pair_break(eff_cls, item.right_class);
	end

	// Decide the break, advance the state and show the advanced state in stateful mode, else the held state
	always_comb begin
		state_nxt.valid = 1'b1;
		state_nxt.cls   = class_advance(eff_cls, item.right_class);
		state_nxt.incb  = incb_advance(eff_incb, item.right_incb);
		if (item.stateful_mode) begin
			// GB9c: no break inside a conjunct cluster
			result.break_allowed = brk_pair &&
				!(eff_incb == ICB_LINKER && item.right_incb == ICB_CONSONANT);
			result.next_class    = state_nxt.cls;
			result.next_incb     = state_nxt.incb;
		end else begin
			result.break_allowed = brk_pair;
			result.next_class    = state_cur.cls;
			result.next_incb     = state_cur.incb;
		end
	end

endmodule

// ----- verif/grapheme_break_step_test.sv -----
// ----------------------------------------------------------------------------
// grapheme_break_step_test
// Self-checking bench for the grapheme break step. Drives code point pairs in
// stateless and stateful mode, predicts the boundary decision and the kept
// class and conjunct state, and compares every result item in order.
// Random gaps on both channels plus one long output hold-off.
// ----------------------------------------------------------------------------
module grapheme_break_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gbs_pkg::*;

	localparam int CycleLimit  = 1000000;
	localparam int HoldOffLen  = 200;
	localparam int RandomItems = 1750;
	localparam int ReportMax   = 10;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             stateful_mode;
	logic             restart;
	logic [ClsW-1:0]  left_class;
	logic [IncbW-1:0] left_incb;
	logic [ClsW-1:0]  right_class;
	logic [IncbW-1:0] right_incb;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             break_allowed;
	logic [ClsW-1:0]  next_class;
	logic [IncbW-1:0] next_incb;

	// kept state of the predictor
	gbs_state_t  kept;
	gbs_result_t pending_results[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  items_sent = 0;
	bit  sender_gaps_on = 1'b1;
	bit  receiver_gaps_on = 1'b1;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  stall_left = 0;

	grapheme_break_step uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stateful_mode(stateful_mode),
		.restart      (restart),
		.left_class   (left_class),
		.left_incb    (left_incb),
		.right_class  (right_class),
		.right_incb   (right_incb),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.break_allowed(break_allowed),
		.next_class   (next_class),
		.next_incb    (next_incb)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Pick an idle length: mostly none or short, a few long
	function automatic int pick_idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Pairwise boundary rules, GB1 through GB13
	function automatic bit boundary_permitted(logic [ClsW-1:0] a, logic [ClsW-1:0] b);
		if (a == BC_START)
			return 1'b1;
		if (a == BC_CR && b == BC_LF)
			return 1'b0;
		if (a >= BC_CR && a <= BC_CONTROL)
			return 1'b1;
		if (b >= BC_CR && b <= BC_CONTROL)
			return 1'b1;
		if (a == BC_L && (b == BC_L || b == BC_V || b == BC_LV || b == BC_LVT))
			return 1'b0;
		if ((a == BC_LV || a == BC_V) && (b == BC_V || b == BC_T))
			return 1'b0;
		if ((a == BC_LVT || a == BC_T) && b == BC_T)
			return 1'b0;
		if (b == BC_EXTEND || b == BC_ZWJ || b == BC_SPACINGMARK || a == BC_PREPEND)
			return 1'b0;
		if (a == BC_EZWG && b == BC_EXTPICT)
			return 1'b0;
		if (a == BC_RI && b == BC_RI)
			return 1'b0;
		return 1'b1;
	endfunction

	// Advance the conjunct tracking state by one code point
	function automatic logic [IncbW-1:0] conjunct_next(logic [IncbW-1:0] s,
			logic [IncbW-1:0] t);
		if (t == ICB_CONSONANT || s == ICB_CONSONANT || s == ICB_EXTEND)
			return t;
		if (s == ICB_LINKER)
			return (t == ICB_EXTEND) ? ICB_LINKER : t;
		return s;
	endfunction

	// Advance the effective previous class: fold emoji runs, pair up RIs
	function automatic logic [ClsW-1:0] class_next(logic [ClsW-1:0] s, logic [ClsW-1:0] t);
		if (s == BC_RI && t == BC_RI)
			return BC_OTHER;
		if (s == BC_EXTPICT && t == BC_EXTEND)
			return BC_EXTPICT;
		if (s == BC_EXTPICT && t == BC_ZWJ)
			return BC_EZWG;
		return t;
	endfunction

	// Work out the result of one accepted item and update the kept state
	function automatic gbs_result_t predict_boundary(gbs_item_t it);
		gbs_result_t res;
		logic [ClsW-1:0]  eff_class;
		logic [IncbW-1:0] eff_incb;
		if (!it.stateful_mode) begin
			res.break_allowed = boundary_permitted(it.left_class, it.right_class);
		end else begin
			if (!kept.valid || it.restart) begin
				eff_class = it.left_class;
				eff_incb  = (it.left_incb == ICB_CONSONANT) ? ICB_CONSONANT : ICB_NONE;
			end else begin
				eff_class = kept.cls;
				eff_incb  = kept.incb;
			end
			res.break_allowed = boundary_permitted(eff_class, it.right_class) &&
				!(eff_incb == ICB_LINKER && it.right_incb == ICB_CONSONANT);
			kept.cls   = class_next(eff_class, it.right_class);
			kept.incb  = conjunct_next(eff_incb, it.right_incb);
			kept.valid = 1'b1;
		end
		res.next_class = kept.cls;
		res.next_incb  = kept.incb;
		return res;
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(gbs_item_t it);
		int gap;
		gap = sender_gaps_on ? pick_idle_cycles() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stateful_mode <= it.stateful_mode;
		restart       <= it.restart;
		left_class    <= it.left_class;
		left_incb     <= it.left_incb;
		right_class   <= it.right_class;
		right_incb    <= it.right_incb;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_boundary(it));
		items_sent++;
	endtask

	task automatic send_pair(bit mode, bit rst, logic [ClsW-1:0] lc, logic [IncbW-1:0] li,
			logic [ClsW-1:0] rc, logic [IncbW-1:0] ri);
		gbs_item_t it;
		it = '{stateful_mode: mode, restart: rst, left_class: lc, left_incb: li,
			right_class: rc, right_incb: ri};
		send_item(it);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Class biased toward the ones that drive the kept state
	function automatic logic [ClsW-1:0] pick_class();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			case ($urandom_range(0, 4))
				0: return BC_EXTEND;
				1: return BC_ZWJ;
				2: return BC_EXTPICT;
				3: return BC_RI;
				default: return BC_EZWG;
			endcase
		end else if (r < 9) begin
			return ClsW'($urandom_range(0, 16));
		end
		return ClsW'($urandom_range(17, 31));
	endfunction

	// Any conjunct class
	function automatic logic [IncbW-1:0] pick_incb();
		return IncbW'($urandom_range(0, 3));
	endfunction

	// Stall the output: long hold-off on request, otherwise random gaps
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			stall_left  <= HoldOffLen;
			out_stall   <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (receiver_gaps_on && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_idle_cycles();
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		gbs_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("unexpected result: break %0d class %0d incb %0d",
						break_allowed, next_class, next_incb);
			end else begin
				want = pending_results.pop_front();
				if (break_allowed !== want.break_allowed || next_class !== want.next_class ||
						next_incb !== want.next_incb) begin
					mismatches++;
					if (mismatches <= ReportMax)
						$display("mismatch: break %0d/%0d class %0d/%0d incb %0d/%0d (exp/act)",
							want.break_allowed, break_allowed, want.next_class, next_class,
							want.next_incb, next_incb);
				end
			end
		end
	end

	// Stateless pairs: every boundary rule and the out-of-range classes
	task automatic test_pairwise_rules();
		send_pair(1'b0, 1'b0, BC_START, ICB_NONE, BC_OTHER, ICB_NONE);
		send_pair(1'b0, 1'b1, BC_CR, ICB_NONE, BC_LF, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_CR, ICB_NONE, BC_OTHER, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_OTHER, ICB_NONE, BC_LF, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_CONTROL, ICB_NONE, BC_EXTEND, ICB_EXTEND);
		send_pair(1'b0, 1'b0, BC_L, ICB_NONE, BC_LV, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_LV, ICB_NONE, BC_T, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_LVT, ICB_NONE, BC_T, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_OTHER, ICB_NONE, BC_ZWJ, ICB_EXTEND);
		send_pair(1'b0, 1'b0, BC_PREPEND, ICB_NONE, BC_OTHER, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_EZWG, ICB_NONE, BC_EXTPICT, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_RI, ICB_NONE, BC_RI, ICB_NONE);
		send_pair(1'b0, 1'b0, BC_OTHER, ICB_LINKER, BC_SPACINGMARK, ICB_CONSONANT);
		send_pair(1'b0, 1'b1, 5'd31, ICB_LINKER, 5'd31, ICB_LINKER);
		release_input();
	endtask

	// Kept state: emoji ZWJ run, regional indicator pairs, conjunct linker
	task automatic test_kept_state();
		send_pair(1'b1, 1'b1, BC_EXTPICT, ICB_NONE, BC_EXTEND, ICB_NONE);
		send_pair(1'b1, 1'b0, 5'd31, ICB_LINKER, BC_ZWJ, ICB_NONE);
		send_pair(1'b1, 1'b0, BC_START, ICB_NONE, BC_EXTPICT, ICB_NONE);
		send_pair(1'b1, 1'b1, BC_RI, ICB_NONE, BC_RI, ICB_NONE);
		send_pair(1'b1, 1'b0, BC_OTHER, ICB_NONE, BC_RI, ICB_NONE);
		send_pair(1'b1, 1'b1, BC_OTHER, ICB_CONSONANT, BC_EXTEND, ICB_LINKER);
		send_pair(1'b1, 1'b0, BC_OTHER, ICB_NONE, BC_OTHER, ICB_CONSONANT);
		send_pair(1'b0, 1'b1, BC_CR, ICB_CONSONANT, BC_CONTROL, ICB_NONE);
		send_pair(1'b1, 1'b0, BC_OTHER, ICB_NONE, BC_EXTEND, ICB_EXTEND);
		release_input();
	endtask

	// Hold the output off while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		int n;
		sender_gaps_on = 1'b0;
		hold_requests++;
		for (n = 0; n < 30; n++)
			send_pair(1'b1, $urandom_range(0, 7) == 0, pick_class(), pick_incb(),
				pick_class(), pick_incb());
		release_input();
		sender_gaps_on = 1'b1;
		wait_drain();
	endtask

	// Random stream: emoji and conjunct runs, random pairs in both modes, some noise
	task automatic test_random_stream();
		int target;
		int n;
		int k;
		target = items_sent + RandomItems;
		while (items_sent < target) begin
			if ($urandom_range(0, 15) == 0) begin
				sender_gaps_on   = $urandom_range(0, 2) != 0;
				receiver_gaps_on = $urandom_range(0, 2) != 0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// pictographic, extends, ZWJ, pictographic
					send_pair(1'b1, $urandom_range(0, 3) == 0, pick_class(),
						pick_incb(), BC_EXTPICT, pick_incb());
					n = $urandom_range(0, 3);
					for (k = 0; k < n; k++)
						send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
							BC_EXTEND, pick_incb());
					if ($urandom_range(0, 4) != 0)
						send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
							BC_ZWJ, pick_incb());
					send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
						$urandom_range(0, 4) != 0 ? BC_EXTPICT : pick_class(),
						pick_incb());
				end
				3, 4: begin
					// consonant, extends, linker, extends, consonant
					send_pair(1'b1, $urandom_range(0, 3) == 0, pick_class(),
						pick_incb(), pick_class(), ICB_CONSONANT);
					n = $urandom_range(0, 2);
					for (k = 0; k < n; k++)
						send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
							pick_class(), ICB_EXTEND);
					send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
						pick_class(), ICB_LINKER);
					n = $urandom_range(0, 2);
					for (k = 0; k < n; k++)
						send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
							pick_class(), $urandom_range(0, 4) != 0 ? ICB_EXTEND : ICB_LINKER);
					send_pair(1'b1, 1'b0, pick_class(), pick_incb(),
						pick_class(), $urandom_range(0, 3) != 0 ? ICB_CONSONANT : ICB_NONE);
				end
				5, 6, 7: begin
					n = $urandom_range(1, 8);
					for (k = 0; k < n; k++)
						send_pair(1'b1, $urandom_range(0, 15) == 0, pick_class(),
							pick_incb(), pick_class(), pick_incb());
				end
				8: begin
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						send_pair(1'b0, 1'($urandom_range(0, 1)), pick_class(),
							pick_incb(), pick_class(), pick_incb());
				end
				default: begin
					// raw noise over every bit
					send_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						ClsW'($urandom_range(0, 31)), pick_incb(),
						ClsW'($urandom_range(0, 31)), pick_incb());
				end
			endcase
		end
		release_input();
		sender_gaps_on   = 1'b1;
		receiver_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		stateful_mode = 1'b0;
		restart       = 1'b0;
		left_class    = '0;
		left_incb     = '0;
		right_class   = '0;
		right_incb    = '0;
		kept          = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pairwise_rules();
		test_kept_state();
		test_output_backpressure();
		test_random_stream();
		wait_drain();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/gbs_pkg.sv
hdl/gbs_core.sv
hdl/grapheme_break_step.sv
verif/grapheme_break_step_test.sv
